>>> sv/huffman_byte_packer_assert.svh
// ----------------------------------------------------------------------------
// huffman_byte_packer_assert
// Assertion macros for the packer RTL.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_BYTE_PACKER_ASSERT_SVH
`define HUFFMAN_BYTE_PACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HPK_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HPK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/hpk_pkg.sv
// ----------------------------------------------------------------------------
// hpk_pkg
// Types and fixed constants of the Huffman byte packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hpk_pkg;

   localparam int ACC_BITS = 64;
   localparam int BYTE_W   = 8;
   localparam int WIDTH_W  = 6;
   localparam int CODE_W   = 56;
   localparam int PEND_W   = 7;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] width;
      logic [CODE_W-1:0]  code;
   } entry_type;

endpackage

`default_nettype wire

>>> sv/huffman_byte_packer.sv
// ----------------------------------------------------------------------------
// huffman_byte_packer
// Huffman bit packer for 64-bit words of byte symbols.
// ----------------------------------------------------------------------------
// After reset the block clears every code entry in all lanes, one symbol per
// cycle, and holds req_ready low until that pass is done. A load word writes
// one symbol's code into every lane. An encode word looks up all of its
// symbols at once, one lane per byte, then the merge stage appends the codes
// one symbol per cycle and sends a byte in a cycle of its own whenever the
// next code would not fit in the 64-bit accumulator. A flush pads to a byte
// boundary and drains the pending bytes. A byte or error word that meets
// the result register holding an untaken word waits there; appends go on
// regardless.
`timescale 1ns / 1ps
`default_nettype none

`include "huffman_byte_packer_assert.svh"

module huffman_byte_packer
   import hpk_pkg::*;
#(
   parameter int SYMBOL_COUNT     = 256,
   parameter int MAX_CODE_WIDTH   = 56,
   parameter int SYMBOLS_PER_WORD = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [1:0]    req_cmd,
   input  wire logic [7:0]    req_symbol,
   input  wire logic [5:0]    req_code_width,
   input  wire logic [55:0]   req_code_bits,
   input  wire logic [63:0]   req_data_word,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last,
   output logic               rsp_error
);

   localparam int IDX_W = (SYMBOLS_PER_WORD > 1) ? $clog2(SYMBOLS_PER_WORD) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPEND,
      ST_FLUSH
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [PEND_W-1:0]     pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     rsp_byte_ff, rsp_byte_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_error_ff, rsp_error_in;
   logic                  clr_busy_ff, clr_busy_in;
   logic [7:0]            clr_idx_ff, clr_idx_in;

   logic                  accept;
   logic                  out_free;
   cmd_type               cmd;
   logic [WIDTH_W-1:0]    ld_width;
   logic [CODE_W-1:0]     ld_mask;
   entry_type             ld_entry;
   logic                  ld_en;
   logic                  rd_en;
   logic                  wr_en;
   logic [7:0]            wr_sym;
   entry_type             wr_entry;
   entry_type             lane_entry [SYMBOLS_PER_WORD];
   entry_type             cur;
   logic [7:0]            fit_sum;
   logic [BYTE_W-1:0]     top_byte;
   logic [2:0]            pad;

   assign cmd       = cmd_type'(req_cmd);
   assign req_ready = (state_ff == ST_IDLE) && !clr_busy_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // clamp the loaded width and clear stray bits above it
   assign ld_width = (req_code_width > 6'(MAX_CODE_WIDTH)) ? 6'(MAX_CODE_WIDTH)
                                                           : req_code_width;
   assign ld_mask  = {CODE_W{1'b1}} >> (7'(CODE_W) - 7'(ld_width));
   assign ld_entry = '{width: ld_width, code: req_code_bits & ld_mask};
   assign ld_en    = accept && (cmd == CMD_LOAD)
                     && ({1'b0, req_symbol} < 9'(SYMBOL_COUNT));
   assign rd_en    = accept && (cmd == CMD_ENCODE);

   // the clearing pass owns the table write port until it is done
   assign wr_en    = ld_en || clr_busy_ff;
   assign wr_sym   = clr_busy_ff ? clr_idx_ff : req_symbol;
   assign wr_entry = clr_busy_ff ? entry_type'('0) : ld_entry;

   for (genvar g = 0; g < SYMBOLS_PER_WORD; g++) begin : g_lane
      hpk_lane #(
         .SYMBOL_COUNT (SYMBOL_COUNT)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (wr_en),
         .wr_sym   (wr_sym),
         .wr_entry (wr_entry),
         .rd_en    (rd_en),
         .rd_sym   (req_data_word[8*g +: 8]),
         .rd_entry (lane_entry[g])
      );
   end

   // merge stage: walk the lane results in byte order
   assign cur      = lane_entry[idx_ff];
   assign fit_sum  = {1'b0, pend_ff} + {2'b00, cur.width};
   assign top_byte = BYTE_W'(acc_ff >> (pend_ff - 7'd8));
   assign pad      = 3'(7'd0 - pend_ff);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_error_in = rsp_error_ff;
      clr_busy_in  = clr_busy_ff;
      clr_idx_in   = clr_idx_ff;
      // advance the clearing pass, one symbol per cycle
      if (clr_busy_ff) begin
         if (clr_idx_ff == 8'(SYMBOL_COUNT - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_idx_in = clr_idx_ff + 8'd1;
         end
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_ENCODE: begin
                     idx_in   = '0;
                     state_in = ST_APPEND;
                  end
                  CMD_FLUSH: begin
                     // pad to a byte boundary, then drain
                     if (pend_ff != '0) begin
                        acc_in   = acc_ff << pad;
                        pend_in  = pend_ff + 7'(pad);
                        state_in = ST_FLUSH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_APPEND: begin
            if (cur.width == '0) begin
               // symbol without code: report and drop the rest of the word
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = '0;
                  rsp_last_in  = 1'b0;
                  rsp_error_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (fit_sum > 8'(ACC_BITS)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = top_byte;
                  rsp_last_in  = 1'b0;
                  rsp_error_in = 1'b0;
                  pend_in      = pend_ff - 7'd8;
               end
            end else begin
               acc_in  = (acc_ff << cur.width) | {{(ACC_BITS-CODE_W){1'b0}}, cur.code};
               pend_in = fit_sum[PEND_W-1:0];
               if (idx_ff == IDX_W'(SYMBOLS_PER_WORD - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = top_byte;
               rsp_last_in  = (pend_ff == 7'd8);
               rsp_error_in = 1'b0;
               pend_in      = pend_ff - 7'd8;
               if (pend_ff == 7'd8) begin
                  acc_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         acc_ff       <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_byte_ff  <= '0;
         rsp_last_ff  <= 1'b0;
         rsp_error_ff <= 1'b0;
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_byte_ff  <= rsp_byte_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_error_ff <= rsp_error_in;
         clr_busy_ff  <= clr_busy_in;
         clr_idx_ff   <= clr_idx_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_error    = rsp_error_ff;

   `HPK_ASSERT_SAME(a_pend_range, clock, reset, 1'b1, pend_ff <= 7'(ACC_BITS), "pending bits above 64")
   `HPK_ASSERT_SAME(a_flush_aligned, clock, reset, state_ff == ST_FLUSH, pend_ff[2:0] == 3'd0, "flush not byte aligned")
   `HPK_ASSERT_SAME(a_error_clean, clock, reset, rsp_valid_ff && rsp_error_ff, rsp_byte_ff == '0 && !rsp_last_ff, "error word carries data")
   `HPK_ASSERT_NEXT(a_encode_start, clock, reset, rd_en, state_ff == ST_APPEND && idx_ff == '0, "encode did not start merge")

endmodule

`default_nettype wire

>>> sv/hpk_lane.sv
// ----------------------------------------------------------------------------
// hpk_lane
// One lookup lane: a private copy of the code table, read at one symbol.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpk_lane
   import hpk_pkg::*;
#(
   parameter int SYMBOL_COUNT = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        wr_en,
   input  wire logic [7:0]  wr_sym,
   input  wire entry_type   wr_entry,
   input  wire logic        rd_en,
   input  wire logic [7:0]  rd_sym,
   output entry_type        rd_entry
);

   localparam int ADDR_W = $clog2(SYMBOL_COUNT);

   entry_type               table_mem [SYMBOL_COUNT];
   entry_type               rd_data_ff;
   logic                    rd_range_ff;
   logic                    rd_range;

   assign rd_range = {1'b0, rd_sym} < 9'(SYMBOL_COUNT);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_sym[ADDR_W-1:0]] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_sym[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_range_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_range_ff <= rd_range;
         end
      end
   end

   // out-of-range symbols read as width zero
   assign rd_entry = rd_range_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire
